FILE: hw/rtl/gtpg_pkg.sv
`timescale 1ns / 1ps

package gtpg_pkg;

  // LCG and sequence-mix constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] SEQ_MIX = 32'd2654435761;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_AMP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED   = 8'd3;

  // Input beat
  typedef struct packed {
    logic        start_frame;
    logic [31:0] frame_seq;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic        end_of_frame;
  } out_beat_t;

  // Configuration register file contents
  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [7:0]  noise_amp;
    logic [31:0] noise_seed;
  } cfg_regs_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;
    logic mix;
    logic step;
    logic div_step;
    logic emit;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic in_start;
    logic amp_nz;
    logic div_last;
    logic out_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_STEP,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

FILE: hw/rtl/gradient_test_pattern_generator_unit.sv
`timescale 1ns / 1ps
// Gradient test pattern generator: raster-order RGB frame with LCG noise.
// Input channel (in_valid/in_ready/in_data): one beat asks for one pixel.
//   A beat with start_frame set restarts at pixel (0,0), takes the scroll
//   phase from frame_seq[7:0] and reseeds the noise LCG from frame_seq.
// Output channel (out_valid/out_ready/out_data): one pixel beat per input
//   beat, in order, with its coordinates and an end-of-frame flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   index 0 width, 1 height, 2 noise amplitude, 3 noise seed. Write only
//   while the block is idle.
// Sequence: one beat is worked at a time. A start beat passes a seed-mix
//   state (seed multiply) after the accept; with noise on, an LCG step and a
//   bit-serial remainder loop follow before the emit state. A new beat is
//   taken only once the last one is emitted; the remainder loop dominates.
// The output register holds a finished pixel while a new beat is accepted
//   and worked; if out_ready stays low the block waits at its output stage.
// Reset (rst_n, synchronous): coordinates, phase and LCG go to zero, config
//   returns to 320x240, amplitude 8, seed 0.
module gradient_test_pattern_generator_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gtpg_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gtpg_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gtpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  gtpg_pkg::cfg_regs_t regs;
  gtpg_pkg::cmd_t      cmd;
  gtpg_pkg::sts_t      sts;

  gtpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  gtpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtpg_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .regs      (regs),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // One beat in flight: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous beat still in work");

  // A pixel is only written when the output register can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("pixel written over an untaken output beat");

  // A new output beat always comes from an emit command
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid raised without an emit");
`endif

endmodule

FILE: hw/rtl/gtpg_cfg.sv
`timescale 1ns / 1ps

module gtpg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gtpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  output gtpg_pkg::cfg_regs_t              regs
);

  gtpg_pkg::cfg_regs_t regs_r;
  gtpg_pkg::cfg_regs_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  // Register decode; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        gtpg_pkg::CFG_FRAME_WIDTH:  regs_nxt.frame_width  = cfg_data[12:0];
        gtpg_pkg::CFG_FRAME_HEIGHT: regs_nxt.frame_height = cfg_data[12:0];
        gtpg_pkg::CFG_NOISE_AMP:    regs_nxt.noise_amp    = cfg_data[7:0];
        gtpg_pkg::CFG_NOISE_SEED:   regs_nxt.noise_seed   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.frame_width  <= 13'd320;
      regs_r.frame_height <= 13'd240;
      regs_r.noise_amp    <= 8'd8;
      regs_r.noise_seed   <= 32'd0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

FILE: hw/rtl/gtpg_ctrl.sv
`timescale 1ns / 1ps

module gtpg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gtpg_pkg::sts_t sts,
  output gtpg_pkg::cmd_t cmd
);

  gtpg_pkg::state_t state_r;
  gtpg_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtpg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gtpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_start) begin
            state_nxt = gtpg_pkg::ST_MIX;
          end else if (sts.amp_nz) begin
            state_nxt = gtpg_pkg::ST_STEP;
          end else begin
            state_nxt = gtpg_pkg::ST_EMIT;
          end
        end
      end
      gtpg_pkg::ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = sts.amp_nz ? gtpg_pkg::ST_STEP : gtpg_pkg::ST_EMIT;
      end
      gtpg_pkg::ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = gtpg_pkg::ST_DIV;
      end
      gtpg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = gtpg_pkg::ST_EMIT;
        end
      end
      gtpg_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = gtpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gtpg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/gtpg_dp.sv
`timescale 1ns / 1ps

module gtpg_dp #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gtpg_pkg::in_beat_t  in_data,
  input  gtpg_pkg::cfg_regs_t regs,
  input  gtpg_pkg::cmd_t      cmd,
  output gtpg_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output gtpg_pkg::out_beat_t out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned EW    = (DIM_W > 13) ? DIM_W : 13;
  localparam int unsigned DIV_STEPS = 9;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  // Item and generator state
  logic [31:0]       seq_r;
  logic [31:0]       lcg_r, lcg_nxt;
  logic [7:0]        phase_r;
  logic [CNT_W-1:0]  col_r, row_r;

  // Remainder unit
  logic [8:0]        rem_r, dvd_r;
  logic [DCNT_W-1:0] dcnt_r;

  // Output register
  logic                out_valid_r;
  gtpg_pkg::out_beat_t out_r, pix;

  logic [31:0] mix_lo;
  logic [8:0]  span;
  logic [9:0]  trial;
  logic [8:0]  rem_nxt;
  logic [EW-1:0] w_raw, h_raw, w_eff, h_eff;
  logic        last_col, last_row;
  logic signed [9:0] noise;
  logic [7:0]  base_r, base_g, base_b;

  function automatic logic [7:0] clamp_ch(input logic [7:0] base, input logic signed [9:0] n);
    logic signed [10:0] s;
    s = $signed({3'b000, base}) + $signed({n[9], n});
    if (s < 0) begin
      clamp_ch = 8'd0;
    end else if (s > 11'sd255) begin
      clamp_ch = 8'd255;
    end else begin
      clamp_ch = s[7:0];
    end
  endfunction

  // Seed mix and LCG step
  assign mix_lo  = seq_r * gtpg_pkg::SEQ_MIX;
  assign lcg_nxt = lcg_r * gtpg_pkg::LCG_MUL + gtpg_pkg::LCG_ADD;

  // One restoring remainder step per cycle
  assign span    = {regs.noise_amp, 1'b1};
  assign trial   = {rem_r, dvd_r[8]};
  assign rem_nxt = (trial >= {1'b0, span}) ? 9'(trial - {1'b0, span}) : trial[8:0];

  // Effective frame size
  assign w_raw = EW'(regs.frame_width);
  assign h_raw = EW'(regs.frame_height);
  always_comb begin
    w_eff = w_raw;
    if (w_raw == '0) begin
      w_eff = EW'(1);
    end else if (w_raw > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end
    h_eff = h_raw;
    if (h_raw == '0) begin
      h_eff = EW'(1);
    end else if (h_raw > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end
  end

  assign last_col = EW'(col_r) >= (w_eff - EW'(1));
  assign last_row = EW'(row_r) >= (h_eff - EW'(1));

  // Pixel assembly
  assign noise  = $signed({1'b0, rem_r}) - $signed({2'b00, regs.noise_amp});
  assign base_r = 8'(col_r) + phase_r;
  assign base_g = 8'(row_r) + phase_r;
  assign base_b = 8'(col_r) + 8'(row_r);

  always_comb begin
    pix.red          = clamp_ch(base_r, noise);
    pix.green        = clamp_ch(base_g, noise);
    pix.blue         = clamp_ch(base_b, noise);
    pix.pixel_col    = 12'(col_r);
    pix.pixel_row    = 12'(row_r);
    pix.end_of_frame = last_col && last_row;
  end

  // Status
  assign sts.in_start = in_data.start_frame;
  assign sts.amp_nz   = (regs.noise_amp != 8'd0);
  assign sts.div_last = (dcnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control state: coordinates, phase, LCG, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      phase_r     <= '0;
      lcg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_data.start_frame) begin
        col_r   <= '0;
        row_r   <= '0;
        phase_r <= in_data.frame_seq[7:0];
      end
      if (cmd.mix) begin
        lcg_r <= regs.noise_seed ^ mix_lo;
      end
      if (cmd.step) begin
        lcg_r <= lcg_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : CNT_W'(row_r + 1'b1);
        end else begin
          col_r <= CNT_W'(col_r + 1'b1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= in_data.frame_seq;
      rem_r <= '0;
    end
    if (cmd.step) begin
      dvd_r  <= lcg_nxt[31:23];
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[7:0], 1'b0};
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.emit) begin
      out_r <= pix;
    end
  end

endmodule

FILE: test/tb_gradient_test_pattern_generator_unit.sv
`timescale 1ns / 1ps

module tb_gradient_test_pattern_generator_unit;

  localparam int MAX_DIM     = 4096;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 20;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 75;
  localparam logic [gtpg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [gtpg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'd255;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  gtpg_pkg::in_beat_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  gtpg_pkg::out_beat_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [gtpg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_data;

  // Shadow of the configuration registers
  logic [12:0] sh_width;
  logic [12:0] sh_height;
  logic [7:0]  sh_amp;
  logic [31:0] sh_seed;

  // Shadow of the raster state
  int          sh_col;
  int          sh_row;
  int          sh_phase;
  logic [31:0] sh_lcg;

  gtpg_pkg::out_beat_t expected_pixels[$];
  int        error_count;
  int        cycle_count;
  bit        in_burst;
  bit        out_burst;
  int        stall_left;

  gradient_test_pattern_generator_unit #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int eff_dim(logic [12:0] v);
    if (v == 13'd0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (in_burst) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic reset_shadow();
    sh_width  = 13'd320;
    sh_height = 13'd240;
    sh_amp    = 8'd8;
    sh_seed   = 32'd0;
    sh_col    = 0;
    sh_row    = 0;
    sh_phase  = 0;
    sh_lcg    = 32'd0;
  endtask

  // Next pixel of the raster, pushed as the expected beat
  task automatic predict_pixel(input gtpg_pkg::in_beat_t beat);
    int                  w;
    int                  h;
    int                  noise;
    int unsigned         span;
    bit                  last_col;
    bit                  last_row;
    gtpg_pkg::out_beat_t px;
    w = eff_dim(sh_width);
    h = eff_dim(sh_height);
    noise = 0;
    if (beat.start_frame) begin
      sh_col   = 0;
      sh_row   = 0;
      sh_phase = int'(beat.frame_seq[7:0]);
      sh_lcg   = sh_seed ^ (beat.frame_seq * gtpg_pkg::SEQ_MIX);
    end
    if (sh_amp != 8'd0) begin
      span   = 2 * int'(sh_amp) + 1;
      sh_lcg = sh_lcg * gtpg_pkg::LCG_MUL + gtpg_pkg::LCG_ADD;
      noise  = int'((sh_lcg >> 23) % span) - int'(sh_amp);
    end
    px.red          = clamp8(((sh_col + sh_phase) & 255) + noise);
    px.green        = clamp8(((sh_row + sh_phase) & 255) + noise);
    px.blue         = clamp8(((sh_col + sh_row) & 255) + noise);
    px.pixel_col    = sh_col[11:0];
    px.pixel_row    = sh_row[11:0];
    last_col        = sh_col >= w - 1;
    last_row        = sh_row >= h - 1;
    px.end_of_frame = last_col && last_row;
    expected_pixels.push_back(px);
    if (last_col) begin
      sh_col = 0;
      sh_row = last_row ? 0 : sh_row + 1;
    end else begin
      sh_col = sh_col + 1;
    end
  endtask

  // Send one request beat; valid is left high so back-to-back beats stay gapless
  task automatic send_pixel(input logic start, input logic [31:0] seq);
    int                 gap;
    gtpg_pkg::in_beat_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.start_frame = start;
    beat.frame_seq   = seq;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(beat);
  endtask

  // Stop sending and let every pending pixel come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gtpg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gtpg_pkg::CFG_FRAME_WIDTH:  sh_width  = data[12:0];
      gtpg_pkg::CFG_FRAME_HEIGHT: sh_height = data[12:0];
      gtpg_pkg::CFG_NOISE_AMP:    sh_amp    = data[7:0];
      gtpg_pkg::CFG_NOISE_SEED:   sh_seed   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Dimension write with junk in the unused upper bits
  task automatic write_dim(input logic [gtpg_pkg::CFG_IDX_W-1:0] idx, input logic [12:0] v);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(idx, {junk[31:13], v});
  endtask

  task automatic write_all(input logic [12:0] w, input logic [12:0] h,
                           input logic [7:0] amp, input logic [31:0] seed);
    write_dim(gtpg_pkg::CFG_FRAME_WIDTH, w);
    write_dim(gtpg_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(gtpg_pkg::CFG_NOISE_AMP, {16'($urandom_range(16'hFFFF)), 8'h00, amp});
    write_reg(gtpg_pkg::CFG_NOISE_SEED, seed);
  endtask

  // Output ready with random stalls
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_burst) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(99);
      if (r < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= (r < 95) ? $urandom_range(2, 0) : $urandom_range(35, 5);
      end
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Pixel checker
  always @(posedge clk) begin
    gtpg_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel beat, expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("red", want.red, out_data.red);
        compare_field("green", want.green, out_data.green);
        compare_field("blue", want.blue, out_data.blue);
        compare_field("pixel_col", want.pixel_col, out_data.pixel_col);
        compare_field("pixel_row", want.pixel_row, out_data.pixel_row);
        compare_field("end_of_frame", want.end_of_frame, out_data.end_of_frame);
      end
    end
  end

  // Pixels from the reset state, then a start with sequence zero
  task automatic test_reset_state();
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b0, 32'h0000_0000);
    send_pixel(1'b1, 32'h0000_0000);
    send_pixel(1'b0, 32'h1234_5678);
    send_pixel(1'b0, 32'h0000_0000);
    wait_drained();
  endtask

  // Tiny frame without noise: line wrap, end of frame, wrap to origin
  task automatic test_small_frame();
    write_all(13'd3, 13'd2, 8'd0, 32'd0);
    send_pixel(1'b1, 32'hFFFF_FFFF);
    repeat (6) send_pixel(1'b0, $urandom());
    wait_drained();
  endtask

  // Full amplitude with phase 255 hits both clamp limits
  task automatic test_clamp();
    write_all(13'd2, 13'd2, 8'd255, 32'hFFFF_FFFF);
    send_pixel(1'b1, 32'h0000_00FF);
    send_pixel(1'b0, $urandom());
    wait_drained();
    write_reg(gtpg_pkg::CFG_NOISE_AMP, 32'd1);
    send_pixel(1'b0, $urandom());
    send_pixel(1'b0, $urandom());
    wait_drained();
  endtask

  // Zero and oversized dimensions, then a width shrunk mid-line
  task automatic test_dimensions();
    write_all(13'd0, 13'd0, 8'd8, 32'hA5A5_5A5A);
    send_pixel(1'b0, $urandom());
    send_pixel(1'b1, $urandom());
    wait_drained();
    write_dim(gtpg_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    write_dim(gtpg_pkg::CFG_FRAME_HEIGHT, 13'd1);
    send_pixel(1'b1, $urandom());
    send_pixel(1'b0, $urandom());
    send_pixel(1'b0, $urandom());
    wait_drained();
    write_dim(gtpg_pkg::CFG_FRAME_WIDTH, 13'd2);
    send_pixel(1'b0, $urandom());
    wait_drained();
  endtask

  // Writes to unused indexes leave the registers alone
  task automatic test_unused_index();
    write_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_HI, 32'h0000_0000);
    send_pixel(1'b0, $urandom());
    wait_drained();
  endtask

  // Random settings, mostly whole frames with the odd restart mid-frame
  task automatic test_random_frames();
    int          r;
    logic [12:0] w;
    logic [12:0] h;
    logic [7:0]  amp;
    logic [31:0] seed;
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(99);
      w = (r < 8) ? 13'd0 : (r < 12) ? 13'h1FFF : (r < 16) ? 13'd4096 :
          13'($urandom_range(12, 1));
      r = $urandom_range(99);
      h = (r < 8) ? 13'd0 : (r < 12) ? 13'h1FFF : 13'($urandom_range(6, 1));
      r = $urandom_range(99);
      amp = (r < 20) ? 8'd0 : (r < 30) ? 8'd255 : (r < 40) ? 8'd1 :
            8'($urandom_range(254, 2));
      r = $urandom_range(99);
      seed = (r < 10) ? 32'd0 : (r < 20) ? 32'hFFFF_FFFF : $urandom();
      write_all(w, h, amp, seed);
      in_burst  = (p % 4) == 1;
      out_burst = (p % 5) == 3;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(99);
        if (i == 0) send_pixel(r < 85, $urandom());
        else send_pixel(r < 4, $urandom());
      end
      wait_drained();
      in_burst  = 1'b0;
      out_burst = 1'b0;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    error_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_small_frame();
    test_clamp();
    test_dimensions();
    test_unused_index();
    test_random_frames();

    wait_drained();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/gtpg_pkg.sv
hw/rtl/gtpg_cfg.sv
hw/rtl/gtpg_ctrl.sv
hw/rtl/gtpg_dp.sv
hw/rtl/gradient_test_pattern_generator_unit.sv
test/tb_gradient_test_pattern_generator_unit.sv
